// ===== design/dtu_pkg.sv =====
// dtu_pkg: unit codes, unit lengths, reciprocal constants and the pipeline word
// for the duration splitter; no dependencies
`timescale 1ns / 1ps

package dtu_pkg;

  typedef enum logic [2:0] {
    UNIT_YEAR   = 3'd0,
    UNIT_MONTH  = 3'd1,
    UNIT_DAY    = 3'd2,
    UNIT_HOUR   = 3'd3,
    UNIT_MINUTE = 3'd4,
    UNIT_SECOND = 3'd5
  } unit_t;

  // order in which parts are tried, largest unit first
  localparam unit_t UNIT_ORDER [6] = '{UNIT_YEAR, UNIT_MONTH, UNIT_DAY,
                                       UNIT_HOUR, UNIT_MINUTE, UNIT_SECOND};

  localparam longint unsigned MIN_SECS   = 64'd60;
  localparam longint unsigned HOUR_SECS  = 64'd60 * MIN_SECS;
  localparam longint unsigned DAY_SECS   = 64'd24 * HOUR_SECS;
  localparam longint unsigned YEAR_SECS  = 64'd365 * DAY_SECS + 64'd2425 * DAY_SECS / 64'd10000;
  localparam longint unsigned MONTH_SECS = YEAR_SECS / 64'd12;
  localparam longint unsigned SPAN_SECS  = DAY_SECS * 64'd99;

  localparam logic [24:0] YEAR_LEN  = 25'(YEAR_SECS);
  localparam logic [21:0] MONTH_LEN = 22'(MONTH_SECS);
  localparam logic [16:0] DAY_LEN   = 17'(DAY_SECS);
  localparam logic [11:0] HOUR_LEN  = 12'(HOUR_SECS);
  localparam logic [5:0]  MIN_LEN   = 6'(MIN_SECS);
  localparam logic [23:0] LONG_SPAN = 24'(SPAN_SECS);

  // year: floor reciprocal on the top 20 bits, one correction step after
  localparam logic [27:0] YEAR_RCP  = 28'((64'd1 << 52) / YEAR_SECS);
  // exact ceiling reciprocals for the bounded remainders
  localparam logic [25:0] MONTH_RCP = 26'(((64'd1 << 47) + MONTH_SECS - 64'd1) / MONTH_SECS);
  localparam logic [24:0] DAY_RCP   = 25'(((64'd1 << 41) + DAY_SECS - 64'd1) / DAY_SECS);
  localparam logic [17:0] HOUR_RCP  = 18'(((64'd1 << 29) + HOUR_SECS - 64'd1) / HOUR_SECS);
  localparam logic [12:0] MIN_RCP   = 13'(((64'd1 << 18) + MIN_SECS - 64'd1) / MIN_SECS);

  // one item as it moves down the pipeline
  typedef struct packed {
    logic signed [40:0] d;
    logic               nonpos;
    logic               big;
    logic               ytake;
    logic [47:0]        yp;
    logic [15:0]        yq;
    logic [25:0]        ym;
    logic [24:0]        r1;
    logic [50:0]        mp;
    logic [3:0]         mq;
    logic               mtake;
    logic [23:0]        r2;
    logic [48:0]        dp;
    logic [7:0]         dq;
    logic               dtake;
    logic [16:0]        r3;
    logic [34:0]        hp;
    logic [5:0]         hq;
    logic               htake;
    logic [11:0]        r4;
    logic [24:0]        np;
    logic [6:0]         nq;
    logic               ntake;
    logic [5:0]         r5;
  } work_t;

endpackage

// ===== design/duration_to_time_units.sv =====
// duration_to_time_units: splits a signed duration into up to three unit parts
// depends on dtu_pkg
`timescale 1ns / 1ps

// Takes a signed 41-bit duration in seconds on start (accepted when busy is
// low) and returns between one and three parts, largest unit first, each a
// count and a unit code, with last_part set on the final one. Parts come out
// one per cycle on consecutive cycles, marked by part_valid, and must be taken
// as they appear. A duration passes through a 12-stage pipeline (one unit
// quotient every two stages, the year quotient over three). A new duration can
// be accepted every cycle while each yields a single part; the one result port
// sets the pace, and busy is high while the earlier parts of a multi-part
// duration are being sent. Year and month are used only above 99 days, a unit
// is used only when the remaining seconds strictly exceed its length, and a
// zero or negative duration comes back as one seconds part carrying the value
// unchanged.
module duration_to_time_units
  import dtu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [40:0] duration,
  output logic               part_valid,
  output logic signed [40:0] part_value,
  output logic [2:0]         unit_code,
  output logic               last_part
);

  localparam int LAST = 11;

  // pipeline words and their valid bits
  work_t       w  [0:LAST];
  work_t       wn [1:LAST];
  work_t       in_word;
  logic [LAST:0] v;

  // output shifter: up to three parts of one duration
  logic signed [40:0] slot_val  [3];
  unit_t              slot_unit [3];
  logic [1:0]         ser_cnt;

  // selected parts of the duration leaving the pipeline
  logic signed [40:0] sel_val  [3];
  unit_t              sel_unit [3];
  logic [1:0]         sel_n;

  logic adv;

  // the whole pipeline moves when the shifter is on its last part or empty
  assign adv  = (ser_cnt < 2'd2);
  assign busy = !adv;

  always_comb begin
    in_word   = '0;
    in_word.d = duration;
  end

  // stage logic
  always_comb begin
    logic [25:0] rem0;
    logic        corr;
    logic [40:0] ym_full;
    logic [24:0] yrem;
    logic [24:0] mrem;
    logic [23:0] drem;
    logic [16:0] hrem;
    logic [11:0] nrem;

    for (int k = 1; k <= LAST; k++) begin
      wn[k] = w[k-1];
    end

    // sign check, long-span check, year estimate from the top bits
    wn[1].nonpos = w[0].d[40] || (w[0].d == '0);
    wn[1].big    = !wn[1].nonpos && (w[0].d[39:0] > 40'(LONG_SPAN));
    wn[1].ytake  = !wn[1].nonpos && (w[0].d[39:0] > 40'(YEAR_LEN));
    wn[1].yp     = 48'(w[0].d[39:20]) * 48'(YEAR_RCP);

    // estimate times year length, low bits only
    wn[2].yq = w[1].yp[47:32];
    ym_full  = 41'(w[1].yp[47:32]) * 41'(YEAR_LEN);
    wn[2].ym = ym_full[25:0];

    // estimate is at most one short
    rem0 = w[2].d[25:0] - w[2].ym;
    corr = (rem0 >= 26'(YEAR_LEN));
    yrem = corr ? 25'(rem0 - 26'(YEAR_LEN)) : rem0[24:0];
    wn[3].yq = w[2].yq + 16'(corr);
    priority if (w[2].nonpos) begin
      wn[3].r1 = '0;
    end else if (w[2].ytake) begin
      wn[3].r1 = yrem;
    end else begin
      wn[3].r1 = w[2].d[24:0];
    end

    // month
    wn[4].mtake = w[3].big && (w[3].r1 > 25'(MONTH_LEN));
    wn[4].mp    = 51'(w[3].r1) * 51'(MONTH_RCP);

    wn[5].mq = w[4].mp[50:47];
    mrem     = w[4].r1 - 25'(w[4].mp[50:47]) * 25'(MONTH_LEN);
    wn[5].r2 = w[4].mtake ? mrem[23:0] : w[4].r1[23:0];

    // day
    wn[6].dtake = (w[5].r2 > 24'(DAY_LEN));
    wn[6].dp    = 49'(w[5].r2) * 49'(DAY_RCP);

    wn[7].dq = w[6].dp[48:41];
    drem     = w[6].r2 - 24'(w[6].dp[48:41]) * 24'(DAY_LEN);
    wn[7].r3 = w[6].dtake ? drem[16:0] : w[6].r2[16:0];

    // hour
    wn[8].htake = (w[7].r3 > 17'(HOUR_LEN));
    wn[8].hp    = 35'(w[7].r3) * 35'(HOUR_RCP);

    wn[9].hq = w[8].hp[34:29];
    hrem     = w[8].r3 - 17'(w[8].hp[34:29]) * 17'(HOUR_LEN);
    wn[9].r4 = w[8].htake ? hrem[11:0] : w[8].r3[11:0];

    // minute
    wn[10].ntake = (w[9].r4 > 12'(MIN_LEN));
    wn[10].np    = 25'(w[9].r4) * 25'(MIN_RCP);

    wn[11].nq = w[10].np[24:18];
    nrem      = w[10].r4 - 12'(w[10].np[24:18]) * 12'(MIN_LEN);
    wn[11].r5 = w[10].ntake ? nrem[5:0] : w[10].r4[5:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w[0] <= in_word;
      for (int k = 1; k <= LAST; k++) begin
        w[k] <= wn[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[LAST-1:0], start};
    end
  end

  // pick the first three parts that are present
  always_comb begin
    logic signed [40:0] cval [6];
    logic [5:0]         ctake;

    cval[0] = 41'(w[LAST].yq);
    cval[1] = 41'(w[LAST].mq);
    cval[2] = 41'(w[LAST].dq);
    cval[3] = 41'(w[LAST].hq);
    cval[4] = 41'(w[LAST].nq);
    cval[5] = w[LAST].nonpos ? w[LAST].d : 41'(w[LAST].r5);
    ctake   = {w[LAST].nonpos || (w[LAST].r5 != '0), w[LAST].ntake, w[LAST].htake,
               w[LAST].dtake, w[LAST].mtake, w[LAST].ytake};

    sel_n = '0;
    for (int j = 0; j < 3; j++) begin
      sel_val[j]  = '0;
      sel_unit[j] = UNIT_SECOND;
    end
    for (int i = 0; i < 6; i++) begin
      if (ctake[i] && (sel_n != 2'd3)) begin
        sel_val[sel_n]  = cval[i];
        sel_unit[sel_n] = UNIT_ORDER[i];
        sel_n           = sel_n + 2'd1;
      end
    end
  end

  // shifter count: parts still to send, including the one on the ports
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_cnt <= '0;
    end else if (!adv) begin
      ser_cnt <= ser_cnt - 2'd1;
    end else begin
      ser_cnt <= v[LAST] ? sel_n : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv) begin
      slot_val[0]  <= slot_val[1];
      slot_val[1]  <= slot_val[2];
      slot_unit[0] <= slot_unit[1];
      slot_unit[1] <= slot_unit[2];
    end else begin
      for (int j = 0; j < 3; j++) begin
        slot_val[j]  <= sel_val[j];
        slot_unit[j] <= sel_unit[j];
      end
    end
  end

  assign part_valid = (ser_cnt != 2'd0);
  assign last_part  = (ser_cnt == 2'd1);
  assign part_value = slot_val[0];
  assign unit_code  = slot_unit[0];

endmodule

// ===== design/dtu_checker.sv =====
// dtu_checker: port-level checks on the part sequence of the duration splitter
// depends on dtu_pkg; bound to duration_to_time_units
`timescale 1ns / 1ps

module dtu_checker
  import dtu_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               part_valid,
  input logic signed [40:0] part_value,
  input logic [2:0]         unit_code,
  input logic               last_part
);

  // parts of one duration follow back to back, in growing unit code order
  a_unit_order: assert property (@(posedge clk) disable iff (rst)
    part_valid && !last_part |=> part_valid && (unit_code > $past(unit_code)))
    else $error("parts not back to back in unit order");

  // a negative count is only ever the single seconds part
  a_neg_second: assert property (@(posedge clk) disable iff (rst)
    part_valid && part_value[40] |-> (unit_code == UNIT_SECOND) && last_part)
    else $error("negative count outside a lone seconds part");

  // input is held off only while more parts of a word are queued
  a_busy_parts: assert property (@(posedge clk) disable iff (rst)
    busy |-> part_valid && !last_part)
    else $error("busy without pending parts");

  // never more than three parts per word
  a_three_max: assert property (@(posedge clk) disable iff (rst)
    part_valid && !last_part && $past(part_valid && !last_part) |=> part_valid && last_part)
    else $error("more than three parts");

endmodule

bind duration_to_time_units dtu_checker u_dtu_checker (
  .clk        (clk),
  .rst        (rst),
  .busy       (busy),
  .part_valid (part_valid),
  .part_value (part_value),
  .unit_code  (unit_code),
  .last_part  (last_part)
);

// ===== verif/duration_to_time_units_tb.sv =====
// duration_to_time_units_tb: self-checking bench for the duration splitter
// drives durations through start/busy and checks every part against a local predictor
// depends on dtu_pkg and duration_to_time_units
`timescale 1ns / 1ps

module duration_to_time_units_tb;
  import dtu_pkg::*;

  // unit lengths in seconds, kept here so the predictor stands on its own
  localparam longint SECS_MINUTE = 60;
  localparam longint SECS_HOUR   = 60 * SECS_MINUTE;
  localparam longint SECS_DAY    = 24 * SECS_HOUR;
  localparam longint SECS_YEAR   = 365 * SECS_DAY + 2425 * SECS_DAY / 10000;
  localparam longint SECS_MONTH  = SECS_YEAR / 12;
  // year and month only show up above this many seconds
  localparam longint SECS_99DAYS = 99 * SECS_DAY;

  localparam longint DUR_MAX = (64'sd1 <<< 40) - 1;
  localparam longint DUR_MIN = -(64'sd1 <<< 40);

  localparam int RANDOM_WORDS = 80;
  // the last words go in without random idle gaps
  localparam int QUIET_TAIL   = 20;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int MAX_REPORTS  = 10;

  // one part of a split duration
  typedef struct {
    logic signed [40:0] value;
    unit_t              unit;
    logic               last;
  } part_t;

  // one word waiting to be sent; settle means hold off until all parts are back
  typedef struct {
    logic signed [40:0] dur;
    bit                 settle;
  } dur_word_t;

  logic               clk;
  logic               rst      = 1'b1;
  logic               start    = 1'b0;
  logic signed [40:0] duration = '0;
  logic               busy;
  logic               part_valid;
  logic signed [40:0] part_value;
  logic [2:0]         unit_code;
  logic               last_part;

  dur_word_t dur_words [$];   // words not yet presented
  part_t     parts_due [$];   // predicted parts not yet seen
  int        n_words;
  int        n_sent;
  int        n_fail;
  int        n_cycles;
  int        idle_left;
  bit        calm;            // a stretch with no sender gaps

  duration_to_time_units dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .duration   (duration),
    .part_valid (part_valid),
    .part_value (part_value),
    .unit_code  (unit_code),
    .last_part  (last_part)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: splits one accepted duration into its parts, largest unit first
  // ---------------------------------------------------------------------------
  function automatic void split_duration(input logic signed [40:0] d);
    longint unit_len [5];
    unit_t  unit_id [5];
    longint rem;
    longint quo;
    bit     long_span;
    part_t  p;
    part_t  found [$];
    unit_len = '{SECS_YEAR, SECS_MONTH, SECS_DAY, SECS_HOUR, SECS_MINUTE};
    unit_id  = '{UNIT_YEAR, UNIT_MONTH, UNIT_DAY, UNIT_HOUR, UNIT_MINUTE};
    rem       = longint'(d);
    long_span = rem > SECS_99DAYS;
    for (int i = 0; i < 5; i++) begin
      // year and month are skipped unless the span is long, and a unit is
      // only taken when the remainder strictly exceeds it
      if ((i >= 2 || long_span) && found.size() < 3 && rem > unit_len[i]) begin
        quo     = rem / unit_len[i];
        p.value = 41'(quo);
        p.unit  = unit_id[i];
        p.last  = 1'b0;
        found.push_back(p);
        rem = rem - quo * unit_len[i];
      end
    end
    // leftover seconds, or the whole value when it is zero or negative
    if (found.size() < 3 && (rem > 0 || d <= 0)) begin
      p.value = 41'(rem);
      p.unit  = UNIT_SECOND;
      p.last  = 1'b0;
      found.push_back(p);
    end
    found[found.size() - 1].last = 1'b1;
    foreach (found[i]) parts_due.push_back(found[i]);
  endfunction

  function automatic void add_word(input longint v, input bit settle);
    dur_word_t w;
    w.dur    = 41'(v);
    w.settle = settle;
    dur_words.push_back(w);
  endfunction

  // random duration, spread over the interesting regions
  function automatic longint pick_duration();
    longint lens [5];
    longint base;
    int     k;
    lens = '{SECS_YEAR, SECS_MONTH, SECS_DAY, SECS_HOUR, SECS_MINUTE};
    case ($urandom_range(0, 7))
      0: return longint'($urandom_range(0, 200));
      1: return longint'($urandom_range(0, 200000));
      // just around a whole number of some unit
      2: begin
        k    = $urandom_range(0, 4);
        base = lens[k] * longint'($urandom_range(1, (k == 0) ? 34000 : 400));
        return base + longint'($urandom_range(0, 2)) - 1;
      end
      // just around the long-span threshold
      3: return SECS_99DAYS + longint'($urandom_range(0, 4)) - 2;
      4: return longint'($urandom_range(0, 32'hffff_ffff)) * 64;
      5: return -longint'($urandom_range(0, 1000000));
      // anywhere in the signed field
      default: return longint'($signed(41'({$urandom(), $urandom()})));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus: directed corners, then random durations
  // ---------------------------------------------------------------------------
  initial begin
    longint v;
    // zero, the smallest positives and negatives, and the field extremes
    add_word(0, 1'b0);
    add_word(1, 1'b0);
    add_word(-1, 1'b0);
    add_word(DUR_MIN, 1'b0);
    add_word(DUR_MAX, 1'b0);
    // exact unit lengths fall to the next smaller unit
    add_word(SECS_MINUTE - 1, 1'b0);
    add_word(SECS_MINUTE, 1'b0);
    add_word(SECS_MINUTE + 1, 1'b0);
    add_word(2 * SECS_MINUTE, 1'b0);
    add_word(SECS_HOUR, 1'b1);
    add_word(SECS_HOUR + SECS_MINUTE + 1, 1'b0);
    add_word(SECS_DAY, 1'b0);
    add_word(SECS_DAY + 1, 1'b0);
    // day, hour, minute and second all present: seconds get dropped
    add_word(SECS_DAY + SECS_HOUR + SECS_MINUTE + 1, 1'b0);
    add_word(SECS_MONTH, 1'b0);
    // long-span threshold, exactly and just above
    add_word(SECS_99DAYS, 1'b0);
    add_word(SECS_99DAYS + 1, 1'b0);
    add_word(SECS_YEAR, 1'b0);
    add_word(SECS_YEAR + 1, 1'b0);
    add_word(SECS_YEAR + SECS_MONTH + SECS_DAY + 7, 1'b1);
    add_word(2 * SECS_YEAR, 1'b0);
    add_word(-SECS_DAY, 1'b0);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      v = pick_duration();
      if (v > DUR_MAX) v = DUR_MAX;
      if (v < DUR_MIN) v = DUR_MIN;
      add_word(v, $urandom_range(0, 24) == 0);
    end
    n_words = dur_words.size();
  end

  // ---------------------------------------------------------------------------
  // driver: presents one word at a time, holds it until busy drops
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_words
    bit        taken;
    bit        start_nx;
    dur_word_t w;
    if (rst) begin
      start     <= 1'b0;
      idle_left  = 0;
      calm       = 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) n_sent++;
      if (!(start && !taken)) begin
        start_nx = 1'b0;
        if (idle_left > 0) begin
          idle_left--;
        end else if (dur_words.size() == 0) begin
          start_nx = 1'b0;
        end else if (dur_words[0].settle && (start || parts_due.size() != 0)) begin
          // pause until every part already owed has come back
          start_nx = 1'b0;
        end else begin
          if ($urandom_range(0, 11) == 0) calm = !calm;
          if (!calm && n_sent < n_words - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
            idle_left = $urandom_range(1, 18) - 1;
          end else begin
            w         = dur_words.pop_front();
            duration <= w.dur;
            start_nx  = 1'b1;
          end
        end
        start <= start_nx;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on acceptance, checks each part on its strobe
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_parts
    part_t want;
    if (!rst) begin
      if (start && !busy) split_duration(duration);
      if (part_valid) begin
        if (parts_due.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("unexpected part: value %0d unit %0d last %0b",
                     part_value, unit_code, last_part);
        end else begin
          want = parts_due.pop_front();
          if (part_value !== want.value || unit_code !== want.unit ||
              last_part !== want.last) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS)
              $display("part mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                       want.value, want.unit, want.last,
                       part_value, unit_code, last_part);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // reset, then wait for the words to go in and all parts to come out
  initial begin
    n_sent   = 0;
    n_fail   = 0;
    n_cycles = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (dur_words.size() != 0 || start) @(posedge clk);
    while (parts_due.size() != 0) @(posedge clk);
    // stray parts after the last expected one still count as failures
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (parts_due.size() != 0) n_fail++;
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dtu_pkg.sv
design/duration_to_time_units.sv
design/dtu_checker.sv
verif/duration_to_time_units_tb.sv
